/* hdl/assert_macros.svh */
// Assertion macros for the RTL of the stack engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/bse_pkg.sv */
// Types and constants of the bounded stack engine.
package bse_pkg;

	localparam int OPCODE_W = 3;
	localparam int WORD_W   = 32;
	localparam int POS_W    = 6;
	localparam int STATUS_W = 2;
	localparam int FILL_W   = 7;

	localparam logic [OPCODE_W-1:0] OP_PUSH     = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_POP      = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_PEEK     = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_SEARCH   = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_TRAVERSE = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [OPCODE_W-1:0]      opcode;
		logic signed [WORD_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] data;
		logic [POS_W-1:0]         position;
		logic [STATUS_W-1:0]      status;
		logic [FILL_W-1:0]        fill_count;
		logic                     last;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_TOP,
		S_SCAN,
		S_WALK
	} state_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC
	} cnt_op_t;

	// Per-cycle control from the sequencer to the datapath.
	typedef struct packed {
		logic                emit;
		logic                use_word;
		logic [POS_W-1:0]    position;
		logic [STATUS_W-1:0] status;
		logic                last;
		cnt_op_t             cnt_op;
		logic                wr_en;
	} seq_ctl_t;

endpackage

/* hdl/bse_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hdl/bse_seq.sv */
// Sequencer of the stack engine: command decode, entry index walk and the comparator.
module bse_seq #(
	parameter int DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  bse_pkg::cmd_t                cmd,
	input  logic [$clog2(DEPTH+1)-1:0]   count,
	input  logic [bse_pkg::WORD_W-1:0]   rdata,
	output logic                         busy,
	output logic [$clog2(DEPTH)-1:0]     raddr,
	output bse_pkg::seq_ctl_t            ctl
);

	import bse_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	state_t              state_q, state_d;
	logic [OPCODE_W-1:0] op_q, op_d;
	logic [WORD_W-1:0]   key_q, key_d;
	logic [AW-1:0]       idx_q, idx_d;
	logic [CW-1:0]       cnt_m1;
	logic [AW-1:0]       top_idx;
	logic                full;
	logic                empty;
	logic                hit;

	assign cnt_m1  = count - CW'(1);
	assign top_idx = cnt_m1[AW-1:0];
	assign full    = (count == CW'(DEPTH));
	assign empty   = (count == '0);
	// Comparator: the RAM read data against the held key.
	assign hit     = (rdata == key_q);
	assign busy    = (state_q != S_IDLE);
	assign raddr   = idx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q  <= op_d;
		key_q <= key_d;
		idx_q <= idx_d;
	end

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		key_d   = key_q;
		idx_d   = idx_q;
		ctl     = '{emit: 1'b0, use_word: 1'b0, position: '0, status: ST_OK,
			last: 1'b1, cnt_op: CNT_HOLD, wr_en: 1'b0};
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					op_d  = cmd.opcode;
					key_d = cmd.value;
					if (cmd.opcode == OP_PUSH) begin
						ctl.emit = 1'b1;
						if (full) begin
							ctl.status = ST_FULL;
						end else begin
							ctl.wr_en  = 1'b1;
							ctl.cnt_op = CNT_INC;
						end
					end else if (cmd.opcode == OP_POP || cmd.opcode == OP_PEEK ||
						cmd.opcode == OP_SEARCH || cmd.opcode == OP_TRAVERSE) begin
						if (empty) begin
							ctl.emit   = 1'b1;
							ctl.status = ST_EMPTY;
						end else if (cmd.opcode == OP_SEARCH) begin
							idx_d   = '0;
							state_d = S_SCAN;
						end else if (cmd.opcode == OP_TRAVERSE) begin
							idx_d   = top_idx;
							state_d = S_WALK;
						end else begin
							idx_d   = top_idx;
							state_d = S_TOP;
						end
					end
				end
			end
			S_TOP: begin
				ctl.emit     = 1'b1;
				ctl.use_word = 1'b1;
				ctl.position = POS_W'(idx_q);
				if (op_q == OP_POP) begin
					ctl.cnt_op = CNT_DEC;
				end
				state_d = S_IDLE;
			end
			S_SCAN: begin
				if (hit) begin
					ctl.emit     = 1'b1;
					ctl.position = POS_W'(idx_q);
					state_d      = S_IDLE;
				end else if (idx_q == top_idx) begin
					ctl.emit   = 1'b1;
					ctl.status = ST_NOT_FOUND;
					state_d    = S_IDLE;
				end else begin
					idx_d = idx_q + AW'(1);
				end
			end
			S_WALK: begin
				ctl.emit     = 1'b1;
				ctl.use_word = 1'b1;
				ctl.position = POS_W'(idx_q);
				ctl.last     = (idx_q == '0);
				if (idx_q == '0) begin
					state_d = S_IDLE;
				end else begin
					idx_d = idx_q - AW'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* hdl/bounded_stack_engine.sv */
// A push is answered in the cycle after its start beat; pop and peek first pass the state
// register and the registered RAM read. Search compares entries from the bottom up, one per
// cycle through one comparator, until a hit or the top entry. Traverse streams one result
// beat per cycle from the top entry down. Push leaves busy low, so pushes run one per cycle.
// Reset (arst_n low) empties the stack and idles the sequencer; stored words are not cleared.
// Result beats are strobed by done for one cycle each; the receiver cannot stall them.
`include "assert_macros.svh"

module bounded_stack_engine #(
	parameter int DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  bse_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done,
	output bse_pkg::rsp_t result
);

	import bse_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	logic [CW-1:0]     count_q, cnt_d;
	logic [AW-1:0]     raddr;
	logic [WORD_W-1:0] rdata;
	seq_ctl_t          ctl;
	logic              done_q;
	rsp_t              result_q;

	// Sequencer: decodes the command beat and walks the entry index.
	bse_seq #(
		.DEPTH(DEPTH)
	) u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.count (count_q),
		.rdata (rdata),
		.busy  (busy),
		.raddr (raddr),
		.ctl   (ctl)
	);

	// Entry store: a push writes at the current fill level; read data is registered.
	bse_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ctl.wr_en),
		.waddr(count_q[AW-1:0]),
		.wdata(cmd.value),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Fill level after this cycle's operation.
	always_comb begin
		unique case (ctl.cnt_op)
			CNT_INC: cnt_d = count_q + CW'(1);
			CNT_DEC: cnt_d = count_q - CW'(1);
			default: cnt_d = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= cnt_d;
			done_q  <= ctl.emit;
		end
	end

	// Result register: load on every emitted beat, hold otherwise.
	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			result_q.data       <= ctl.use_word ? rdata : '0;
			result_q.position   <= ctl.position;
			result_q.status     <= ctl.status;
			result_q.fill_count <= FILL_W'(cnt_d);
			result_q.last       <= ctl.last;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// The fill level never passes the stack depth.
	`ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))
	// A full report only comes from a stack holding DEPTH entries.
	`ASSERT_IMP(a_full_level, clk, arst_n, done && result.status == ST_FULL,
		result.fill_count == FILL_W'(DEPTH))
	// An empty report only comes from an empty stack.
	`ASSERT_IMP(a_empty_level, clk, arst_n, done && result.status == ST_EMPTY,
		result.fill_count == '0)
	// A beat that is not the last of its item means the walk is still running.
	`ASSERT_IMP(a_walk_busy, clk, arst_n, done && !result.last, busy)

endmodule

/* sim/stack_checker.sv */
// Checker for the stack engine: predicts result beats and compares them.
`timescale 1ns / 1ps

module stack_checker #(
	parameter int DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  bse_pkg::cmd_t cmd,
	input  logic          done,
	input  bse_pkg::rsp_t result,
	output int            fail_count,
	output int            pending
);
	import bse_pkg::*;

	logic signed [WORD_W-1:0] stack_words [DEPTH];
	int   held;
	rsp_t rsp_due [$];
	rsp_t head_rsp;
	int   fails = 0;

	function void add_due(input logic signed [WORD_W-1:0] d, input int pos,
			input logic [STATUS_W-1:0] st, input logic lst);
		rsp_t r;
		r.data       = d;
		r.position   = pos[POS_W-1:0];
		r.status     = st;
		r.fill_count = held[FILL_W-1:0];
		r.last       = lst;
		rsp_due.push_back(r);
	endfunction

	// Work out every result beat one command causes; spare opcodes cause none.
	function void stack_predict(input cmd_t c);
		int idx;
		logic signed [WORD_W-1:0] top_word;
		if (c.opcode == OP_PUSH) begin
			if (held >= DEPTH) begin
				add_due(0, 0, ST_FULL, 1'b1);
			end else begin
				stack_words[held] = c.value;
				held++;
				add_due(0, 0, ST_OK, 1'b1);
			end
		end else if (c.opcode == OP_POP || c.opcode == OP_PEEK ||
				c.opcode == OP_SEARCH || c.opcode == OP_TRAVERSE) begin
			if (held == 0) begin
				add_due(0, 0, ST_EMPTY, 1'b1);
			end else if (c.opcode == OP_POP || c.opcode == OP_PEEK) begin
				idx = held - 1;
				top_word = stack_words[idx];
				if (c.opcode == OP_POP)
					held = idx;
				add_due(top_word, idx, ST_OK, 1'b1);
			end else if (c.opcode == OP_SEARCH) begin
				idx = 0;
				while (idx < held && stack_words[idx] != c.value)
					idx++;
				if (idx < held)
					add_due(0, idx, ST_OK, 1'b1);
				else
					add_due(0, 0, ST_NOT_FOUND, 1'b1);
			end else begin
				for (idx = held - 1; idx >= 0; idx--)
					add_due(stack_words[idx], idx, ST_OK, idx == 0);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			rsp_due.delete();
			pending    <= 0;
			fail_count <= fails;
		end else begin
			if (done) begin
				if (rsp_due.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: unexpected result beat data=%0d pos=%0d status=%0d fill=%0d last=%0d",
							$time, result.data, result.position, result.status,
							result.fill_count, result.last);
				end else begin
					head_rsp = rsp_due.pop_front();
					if (result.data !== head_rsp.data || result.position !== head_rsp.position ||
							result.status !== head_rsp.status ||
							result.fill_count !== head_rsp.fill_count ||
							result.last !== head_rsp.last) begin
						fails++;
						if (fails <= 10)
							$display("%0t: mismatch, expected data=%0d pos=%0d status=%0d fill=%0d last=%0d, got data=%0d pos=%0d status=%0d fill=%0d last=%0d",
								$time, head_rsp.data, head_rsp.position, head_rsp.status,
								head_rsp.fill_count, head_rsp.last, result.data,
								result.position, result.status, result.fill_count, result.last);
					end
				end
			end
			if (start && !busy)
				stack_predict(cmd);
			pending    <= rsp_due.size();
			fail_count <= fails;
		end
	end

endmodule

/* sim/tb_top.sv */
// Top of the stack engine testbench: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
	import bse_pkg::*;

	localparam int STACK_DEPTH = 64;
	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEM_TARGET = 160;

	// Opcodes the engine has no meaning for; it must drop them silently.
	localparam logic [OPCODE_W-1:0] OP_SPARE_5 = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

	localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
	localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	cmd_t cmd_bus = '0;
	logic busy;
	logic done;
	rsp_t result;

	int fail_count;
	int pending;
	int cycle_count = 0;

	// Stimulus bookkeeping only: occupancy steers the command mix.
	int level       = 0;
	int beats_sent  = 0;
	int idle_pct    = 13;
	logic signed [WORD_W-1:0] last_pushed = '0;

	always #10 clk = ~clk;

	bounded_stack_engine #(.DEPTH(STACK_DEPTH)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd_bus),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	stack_checker #(.DEPTH(STACK_DEPTH)) stack_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd_bus),
		.done       (done),
		.result     (result),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Hard stop if the engine hangs or stops answering.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Favor corner words and the last pushed word so searches hit often.
	function automatic logic signed [WORD_W-1:0] pick_word();
		case ($urandom_range(9))
			0:       return WORD_MAX;
			1:       return WORD_MIN;
			2:       return '0;
			3:       return -1;
			4:       return last_pushed;
			5:       return $urandom_range(15);
			default: return $urandom;
		endcase
	endfunction

	// Present one command beat and hold it until the engine takes it,
	// then maybe drop start for a random gap.
	task automatic send_cmd(input logic [OPCODE_W-1:0] op,
			input logic signed [WORD_W-1:0] v);
		cmd_t c;
		int gap;
		c.opcode = op;
		c.value  = v;
		start   <= 1'b1;
		cmd_bus <= c;
		do @(posedge clk); while (busy);
		if (op == OP_PUSH) begin
			if (level < STACK_DEPTH)
				level++;
			last_pushed = v;
		end
		if (op == OP_POP && level > 0)
			level--;
		if (op <= OP_TRAVERSE) begin
			beats_sent++;
			// Idle schedule: light gaps, then heavy gaps, then back to back.
			if (beats_sent == 55)
				idle_pct = 45;
			else if (beats_sent == 110)
				idle_pct = 0;
		end
		if ($urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 4);
			// Scribble on cmd while start is low; the engine must ignore it.
			c.opcode = OPCODE_W'($urandom_range(7));
			c.value  = $urandom;
			start   <= 1'b0;
			cmd_bus <= c;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold off until every predicted beat has come back.
	task automatic drain_wait();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// One random command from a weighted mix, with a little spare-opcode noise.
	task automatic random_item(input int w_push, input int w_pop, input int w_peek,
			input int w_search, input int w_trav);
		int r;
		logic [OPCODE_W-1:0] op;
		if ($urandom_range(99) < 4) begin
			case ($urandom_range(2))
				0:       op = OP_SPARE_5;
				1:       op = OP_SPARE_6;
				default: op = OP_SPARE_7;
			endcase
		end else begin
			r = $urandom_range(w_push + w_pop + w_peek + w_search + w_trav - 1);
			if (r < w_push)
				op = OP_PUSH;
			else if (r < w_push + w_pop)
				op = OP_POP;
			else if (r < w_push + w_pop + w_peek)
				op = OP_PEEK;
			else if (r < w_push + w_pop + w_peek + w_search)
				op = OP_SEARCH;
			else
				op = OP_TRAVERSE;
		end
		send_cmd(op, pick_word());
		if ($urandom_range(99) < 2)
			drain_wait();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty stack: every read-type command answers empty.
		send_cmd(OP_POP, 0);
		send_cmd(OP_PEEK, WORD_MAX);
		send_cmd(OP_SEARCH, 0);
		send_cmd(OP_TRAVERSE, 0);
		send_cmd(OP_SPARE_5, WORD_MIN);
		// Extremes of the word, with a duplicate to check first-match order.
		send_cmd(OP_PUSH, WORD_MAX);
		send_cmd(OP_PUSH, WORD_MIN);
		send_cmd(OP_PUSH, 0);
		send_cmd(OP_PUSH, -1);
		send_cmd(OP_PUSH, WORD_MAX);
		send_cmd(OP_PEEK, 0);
		send_cmd(OP_SEARCH, WORD_MAX);
		send_cmd(OP_SEARCH, -1);
		send_cmd(OP_SEARCH, 32'sd12345);
		send_cmd(OP_TRAVERSE, -1);
		send_cmd(OP_SPARE_6, -1);
		send_cmd(OP_SPARE_7, 0);
		send_cmd(OP_POP, WORD_MAX);
		send_cmd(OP_POP, 0);
		send_cmd(OP_PEEK, 0);
		send_cmd(OP_SEARCH, WORD_MIN);
		drain_wait();

		// Mixed warm-up, then climb to full and push past it.
		repeat (12) random_item(35, 25, 12, 15, 8);
		while (level < STACK_DEPTH)
			random_item(90, 3, 2, 4, 1);
		repeat (2) send_cmd(OP_PUSH, pick_word());
		send_cmd(OP_TRAVERSE, 0);
		send_cmd(OP_SEARCH, last_pushed);

		// Churn around the top, then drain to empty and pop past it.
		repeat (10) random_item(30, 30, 12, 15, 5);
		while (level > 0)
			random_item(3, 90, 2, 4, 1);
		repeat (2) send_cmd(OP_POP, pick_word());

		// Fill out the rest with the balanced mix.
		while (beats_sent < ITEM_TARGET)
			random_item(35, 25, 12, 15, 8);

		// Let the last beats arrive, then give dropped opcodes time to pass.
		drain_wait();
		repeat (8) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
